// ----- rtl/core/idxlm_pkg.sv -----
// Package with the shared types, sizes and command codes of the indexed line mesh table.
`timescale 1ns / 1ps

package idxlm_pkg;

   localparam int MAX_VERTICES = 256;
   localparam int MAX_LINES = 256;
   localparam int COORD_BITS = 16;

   localparam int FIELD_BITS = 16;
   localparam int LINE_INDEX_BITS = 8;
   localparam int STATUS_BITS = 2;
   localparam int VIDX_BITS = $clog2(MAX_VERTICES);
   localparam int LIDX_BITS = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
   localparam int VCNT_BITS = $clog2(MAX_VERTICES + 1);
   localparam int LCNT_BITS = $clog2(MAX_LINES + 1);
   localparam int ITER_BITS = (VCNT_BITS > LCNT_BITS) ? VCNT_BITS : LCNT_BITS;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_DONE   = 2'd0,
      ST_DEGEN  = 2'd1,
      ST_FULL   = 2'd2,
      ST_BADIDX = 2'd3
   } status_code_type;

   typedef enum logic [0:0] {
      FUNC_ADD = 1'b0,
      FUNC_DELETE = 1'b1
   } func_type;

   typedef struct packed {
      logic                          func;
      logic signed [FIELD_BITS-1:0]  start_x;
      logic signed [FIELD_BITS-1:0]  start_y;
      logic signed [FIELD_BITS-1:0]  end_x;
      logic signed [FIELD_BITS-1:0]  end_y;
      logic [LINE_INDEX_BITS-1:0]    line_index;
   } req_beat_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [VIDX_BITS-1:0]   first_vertex;
      logic [VIDX_BITS-1:0]   second_vertex;
      logic [LCNT_BITS-1:0]   lines_held;
      logic [VCNT_BITS-1:0]   vertices_held;
   } rsp_beat_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
   } vertex_type;

   typedef struct packed {
      logic [VIDX_BITS-1:0] s;
      logic [VIDX_BITS-1:0] e;
   } line_type;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_SCAN_INIT,
      CMD_VREAD,
      CMD_VMATCH,
      CMD_ADD_START,
      CMD_ADD_END,
      CMD_ADD_LINE,
      CMD_LREAD_IDX,
      CMD_LCAPTURE,
      CMD_LREAD_NEXT,
      CMD_LSHIFT,
      CMD_LDEC,
      CMD_LREAD,
      CMD_LREF,
      CMD_DROP_S,
      CMD_DROP_E,
      CMD_VREAD_NEXT,
      CMD_VSHIFT,
      CMD_VDEC,
      CMD_LRENUM,
      CMD_EV_ADJ,
      CMD_FINISH
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type      op;
      status_code_type status;
   } cmd_type;

   typedef struct packed {
      logic is_delete;
      logic degenerate;
      logic bad_index;
      logic full;
      logic a_found;
      logic b_found;
      logic i_at_vc;
      logic i_at_lc;
      logic inext_ge_vc;
      logic inext_ge_lc;
      logic keep_s;
      logic keep_e;
      logic s_in_range;
      logic e_in_range;
      logic rsp_free;
   } dp_status_type;

endpackage

// ----- rtl/core/idxlm_datapath.sv -----
// Datapath of the indexed line mesh table: stores, counters, scan index and result register.
`timescale 1ns / 1ps

module idxlm_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  idxlm_pkg::cmd_type     cmd,
   output idxlm_pkg::dp_status_type stat,
   input  idxlm_pkg::req_beat_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output idxlm_pkg::rsp_beat_type rsp_data
);

   localparam int IB = idxlm_pkg::ITER_BITS;
   localparam int VB = idxlm_pkg::VIDX_BITS;
   localparam int LB = idxlm_pkg::LIDX_BITS;

   idxlm_pkg::vertex_type vmem [idxlm_pkg::MAX_VERTICES];
   idxlm_pkg::line_type   lmem [idxlm_pkg::MAX_LINES];

   idxlm_pkg::req_beat_type item_ff;
   idxlm_pkg::vertex_type vrd_ff;
   idxlm_pkg::line_type   lrd_ff;
   logic [idxlm_pkg::VCNT_BITS-1:0] vc_ff, vc_in;
   logic [idxlm_pkg::LCNT_BITS-1:0] lc_ff, lc_in;
   logic [IB-1:0] i_ff, i_in;
   logic [VB-1:0] a_ff, a_in, b_ff, b_in, sv0_ff, sv0_in, ev0_ff, ev0_in, v_ff, v_in;
   logic a_found_ff, a_found_in, b_found_ff, b_found_in;
   logic keep_s_ff, keep_s_in, keep_e_ff, keep_e_in;
   logic rsp_valid_ff, rsp_valid_in;
   idxlm_pkg::rsp_beat_type rsp_ff, rsp_in;

   idxlm_pkg::vertex_type start_v, end_v, vwdata;
   idxlm_pkg::line_type   lwdata;
   logic [IB:0] inext;
   logic [IB:0] vneed;
   logic vwe, lwe, vre, lre;
   logic [VB-1:0] vwaddr, vraddr;
   logic [LB-1:0] lwaddr, lraddr;

   assign start_v.x = item_ff.start_x[idxlm_pkg::COORD_BITS-1:0];
   assign start_v.y = item_ff.start_y[idxlm_pkg::COORD_BITS-1:0];
   assign end_v.x = item_ff.end_x[idxlm_pkg::COORD_BITS-1:0];
   assign end_v.y = item_ff.end_y[idxlm_pkg::COORD_BITS-1:0];
   assign inext = {1'b0, i_ff} + (IB+1)'(1);
   assign vneed = (IB+1)'(vc_ff) + (IB+1)'(!a_found_ff) + (IB+1)'(!b_found_ff);

   always_comb begin
      stat.is_delete = item_ff.func == idxlm_pkg::FUNC_DELETE;
      stat.degenerate = start_v == end_v;
      stat.bad_index = (IB+1)'(item_ff.line_index) >= (IB+1)'(lc_ff);
      stat.full = (lc_ff >= idxlm_pkg::LCNT_BITS'(idxlm_pkg::MAX_LINES))
         || (vneed > (IB+1)'(idxlm_pkg::MAX_VERTICES));
      stat.a_found = a_found_ff;
      stat.b_found = b_found_ff;
      stat.i_at_vc = i_ff == IB'(vc_ff);
      stat.i_at_lc = i_ff == IB'(lc_ff);
      stat.inext_ge_vc = inext >= (IB+1)'(vc_ff);
      stat.inext_ge_lc = inext >= (IB+1)'(lc_ff);
      stat.keep_s = keep_s_ff;
      stat.keep_e = keep_e_ff;
      stat.s_in_range = (IB+1)'(sv0_ff) < (IB+1)'(vc_ff);
      stat.e_in_range = (IB+1)'(ev0_ff) < (IB+1)'(vc_ff);
      stat.rsp_free = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      vc_in = vc_ff;
      lc_in = lc_ff;
      i_in = i_ff;
      a_in = a_ff;
      b_in = b_ff;
      sv0_in = sv0_ff;
      ev0_in = ev0_ff;
      v_in = v_ff;
      a_found_in = a_found_ff;
      b_found_in = b_found_ff;
      keep_s_in = keep_s_ff;
      keep_e_in = keep_e_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      vwe = 1'b0;
      lwe = 1'b0;
      vre = 1'b0;
      lre = 1'b0;
      vwaddr = i_ff[VB-1:0];
      vraddr = i_ff[VB-1:0];
      lwaddr = i_ff[LB-1:0];
      lraddr = i_ff[LB-1:0];
      vwdata = vrd_ff;
      lwdata = lrd_ff;
      case (cmd.op)
         idxlm_pkg::CMD_SCAN_INIT: begin
            i_in = '0;
            a_found_in = 1'b0;
            b_found_in = 1'b0;
         end
         idxlm_pkg::CMD_VREAD: vre = 1'b1;
         idxlm_pkg::CMD_VMATCH: begin
            if (!a_found_ff && vrd_ff == start_v) begin
               a_found_in = 1'b1;
               a_in = i_ff[VB-1:0];
            end
            if (!b_found_ff && vrd_ff == end_v) begin
               b_found_in = 1'b1;
               b_in = i_ff[VB-1:0];
            end
            i_in = i_ff + IB'(1);
         end
         idxlm_pkg::CMD_ADD_START: begin
            vwe = 1'b1;
            vwaddr = vc_ff[VB-1:0];
            vwdata = start_v;
            a_in = vc_ff[VB-1:0];
            vc_in = vc_ff + idxlm_pkg::VCNT_BITS'(1);
         end
         idxlm_pkg::CMD_ADD_END: begin
            vwe = 1'b1;
            vwaddr = vc_ff[VB-1:0];
            vwdata = end_v;
            b_in = vc_ff[VB-1:0];
            vc_in = vc_ff + idxlm_pkg::VCNT_BITS'(1);
         end
         idxlm_pkg::CMD_ADD_LINE: begin
            lwe = 1'b1;
            lwaddr = lc_ff[LB-1:0];
            lwdata.s = a_ff;
            lwdata.e = b_ff;
            lc_in = lc_ff + idxlm_pkg::LCNT_BITS'(1);
         end
         idxlm_pkg::CMD_LREAD_IDX: begin
            lre = 1'b1;
            lraddr = LB'(item_ff.line_index);
         end
         idxlm_pkg::CMD_LCAPTURE: begin
            sv0_in = lrd_ff.s;
            ev0_in = lrd_ff.e;
            i_in = IB'(item_ff.line_index);
         end
         idxlm_pkg::CMD_LREAD_NEXT: begin
            lre = 1'b1;
            lraddr = inext[LB-1:0];
         end
         idxlm_pkg::CMD_LSHIFT: begin
            lwe = 1'b1;
            i_in = i_ff + IB'(1);
         end
         idxlm_pkg::CMD_LDEC: begin
            lc_in = lc_ff - idxlm_pkg::LCNT_BITS'(1);
            i_in = '0;
            keep_s_in = 1'b0;
            keep_e_in = sv0_ff == ev0_ff;
         end
         idxlm_pkg::CMD_LREAD: lre = 1'b1;
         idxlm_pkg::CMD_LREF: begin
            if (lrd_ff.s == sv0_ff || lrd_ff.e == sv0_ff) keep_s_in = 1'b1;
            if (lrd_ff.s == ev0_ff || lrd_ff.e == ev0_ff) keep_e_in = 1'b1;
            i_in = i_ff + IB'(1);
         end
         idxlm_pkg::CMD_DROP_S: begin
            v_in = sv0_ff;
            i_in = IB'(sv0_ff);
         end
         idxlm_pkg::CMD_DROP_E: begin
            v_in = ev0_ff;
            i_in = IB'(ev0_ff);
         end
         idxlm_pkg::CMD_VREAD_NEXT: begin
            vre = 1'b1;
            vraddr = inext[VB-1:0];
         end
         idxlm_pkg::CMD_VSHIFT: begin
            vwe = 1'b1;
            i_in = i_ff + IB'(1);
         end
         idxlm_pkg::CMD_VDEC: begin
            vc_in = vc_ff - idxlm_pkg::VCNT_BITS'(1);
            i_in = '0;
         end
         idxlm_pkg::CMD_LRENUM: begin
            lwe = 1'b1;
            lwdata.s = (lrd_ff.s > v_ff) ? lrd_ff.s - VB'(1) : lrd_ff.s;
            lwdata.e = (lrd_ff.e > v_ff) ? lrd_ff.e - VB'(1) : lrd_ff.e;
            i_in = i_ff + IB'(1);
         end
         idxlm_pkg::CMD_EV_ADJ: begin
            if (ev0_ff > sv0_ff) ev0_in = ev0_ff - VB'(1);
         end
         idxlm_pkg::CMD_FINISH: begin
            rsp_valid_in = 1'b1;
            rsp_in.status = cmd.status;
            rsp_in.lines_held = lc_ff;
            rsp_in.vertices_held = vc_ff;
            if (cmd.status == idxlm_pkg::ST_DONE && item_ff.func == idxlm_pkg::FUNC_ADD) begin
               rsp_in.first_vertex = a_ff;
               rsp_in.second_vertex = b_ff;
            end else begin
               rsp_in.first_vertex = '0;
               rsp_in.second_vertex = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.op == idxlm_pkg::CMD_LOAD) item_ff <= req_data;
      if (vwe) vmem[vwaddr] <= vwdata;
      if (vre) vrd_ff <= vmem[vraddr];
      if (lwe) lmem[lwaddr] <= lwdata;
      if (lre) lrd_ff <= lmem[lraddr];
      i_ff <= i_in;
      a_ff <= a_in;
      b_ff <= b_in;
      sv0_ff <= sv0_in;
      ev0_ff <= ev0_in;
      v_ff <= v_in;
      a_found_ff <= a_found_in;
      b_found_ff <= b_found_in;
      keep_s_ff <= keep_s_in;
      keep_e_ff <= keep_e_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= '0;
         lc_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vc_ff <= vc_in;
         lc_ff <= lc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

// ----- rtl/core/idxlm_controller.sv -----
// Controller state machine that sequences the scans and shifts of the line mesh table.
`timescale 1ns / 1ps

module idxlm_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  idxlm_pkg::dp_status_type stat,
   output idxlm_pkg::cmd_type       cmd
);

   typedef enum logic [19:0] {
      S_IDLE     = 20'h00001,
      S_CHECK    = 20'h00002,
      S_VS_TEST  = 20'h00004,
      S_VS_CMP   = 20'h00008,
      S_ADD_S    = 20'h00010,
      S_ADD_E    = 20'h00020,
      S_ADD_L    = 20'h00040,
      S_D_CAP    = 20'h00080,
      S_SH_TEST  = 20'h00100,
      S_SH_WR    = 20'h00200,
      S_REF_TEST = 20'h00400,
      S_REF_CMP  = 20'h00800,
      S_DROPS    = 20'h01000,
      S_VSH_TEST = 20'h02000,
      S_VSH_WR   = 20'h04000,
      S_RN_TEST  = 20'h08000,
      S_RN_WR    = 20'h10000,
      S_EVADJ    = 20'h20000,
      S_DROPE    = 20'h40000,
      S_FIN      = 20'h80000
   } state_type;

   state_type state_ff, state_in;
   idxlm_pkg::status_code_type fin_ff, fin_in;
   logic second_ff, second_in;

   always_comb begin
      state_in = state_ff;
      fin_in = fin_ff;
      second_in = second_ff;
      cmd.op = idxlm_pkg::CMD_NONE;
      cmd.status = fin_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = idxlm_pkg::CMD_LOAD;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            second_in = 1'b0;
            fin_in = idxlm_pkg::ST_DONE;
            if (stat.is_delete) begin
               if (stat.bad_index) begin
                  fin_in = idxlm_pkg::ST_BADIDX;
                  state_in = S_FIN;
               end else begin
                  cmd.op = idxlm_pkg::CMD_LREAD_IDX;
                  state_in = S_D_CAP;
               end
            end else if (stat.degenerate) begin
               fin_in = idxlm_pkg::ST_DEGEN;
               state_in = S_FIN;
            end else begin
               cmd.op = idxlm_pkg::CMD_SCAN_INIT;
               state_in = S_VS_TEST;
            end
         end
         S_VS_TEST: begin
            if (stat.i_at_vc) begin
               state_in = S_ADD_S;
            end else begin
               cmd.op = idxlm_pkg::CMD_VREAD;
               state_in = S_VS_CMP;
            end
         end
         S_VS_CMP: begin
            cmd.op = idxlm_pkg::CMD_VMATCH;
            state_in = S_VS_TEST;
         end
         S_ADD_S: begin
            if (stat.full) begin
               fin_in = idxlm_pkg::ST_FULL;
               state_in = S_FIN;
            end else begin
               if (!stat.a_found) cmd.op = idxlm_pkg::CMD_ADD_START;
               state_in = S_ADD_E;
            end
         end
         S_ADD_E: begin
            if (!stat.b_found) cmd.op = idxlm_pkg::CMD_ADD_END;
            state_in = S_ADD_L;
         end
         S_ADD_L: begin
            cmd.op = idxlm_pkg::CMD_ADD_LINE;
            state_in = S_FIN;
         end
         S_D_CAP: begin
            cmd.op = idxlm_pkg::CMD_LCAPTURE;
            state_in = S_SH_TEST;
         end
         S_SH_TEST: begin
            if (stat.inext_ge_lc) begin
               cmd.op = idxlm_pkg::CMD_LDEC;
               state_in = S_REF_TEST;
            end else begin
               cmd.op = idxlm_pkg::CMD_LREAD_NEXT;
               state_in = S_SH_WR;
            end
         end
         S_SH_WR: begin
            cmd.op = idxlm_pkg::CMD_LSHIFT;
            state_in = S_SH_TEST;
         end
         S_REF_TEST: begin
            if (stat.i_at_lc) begin
               state_in = S_DROPS;
            end else begin
               cmd.op = idxlm_pkg::CMD_LREAD;
               state_in = S_REF_CMP;
            end
         end
         S_REF_CMP: begin
            cmd.op = idxlm_pkg::CMD_LREF;
            state_in = S_REF_TEST;
         end
         S_DROPS: begin
            if (!stat.keep_s && stat.s_in_range) begin
               cmd.op = idxlm_pkg::CMD_DROP_S;
               state_in = S_VSH_TEST;
            end else begin
               state_in = S_DROPE;
            end
         end
         S_VSH_TEST: begin
            if (stat.inext_ge_vc) begin
               cmd.op = idxlm_pkg::CMD_VDEC;
               state_in = S_RN_TEST;
            end else begin
               cmd.op = idxlm_pkg::CMD_VREAD_NEXT;
               state_in = S_VSH_WR;
            end
         end
         S_VSH_WR: begin
            cmd.op = idxlm_pkg::CMD_VSHIFT;
            state_in = S_VSH_TEST;
         end
         S_RN_TEST: begin
            if (stat.i_at_lc) begin
               state_in = second_ff ? S_FIN : S_EVADJ;
            end else begin
               cmd.op = idxlm_pkg::CMD_LREAD;
               state_in = S_RN_WR;
            end
         end
         S_RN_WR: begin
            cmd.op = idxlm_pkg::CMD_LRENUM;
            state_in = S_RN_TEST;
         end
         S_EVADJ: begin
            cmd.op = idxlm_pkg::CMD_EV_ADJ;
            state_in = S_DROPE;
         end
         S_DROPE: begin
            if (!stat.keep_e && stat.e_in_range) begin
               cmd.op = idxlm_pkg::CMD_DROP_E;
               second_in = 1'b1;
               state_in = S_VSH_TEST;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (stat.rsp_free) begin
               cmd.op = idxlm_pkg::CMD_FINISH;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fin_ff <= idxlm_pkg::ST_DONE;
         second_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fin_ff <= fin_in;
         second_ff <= second_in;
      end
   end

endmodule

// ----- rtl/core/indexed_line_mesh_table_core.sv -----
// Top level of the indexed line mesh table: controller and datapath joined by commands.
`timescale 1ns / 1ps

// The block keeps one line mesh in two single-port-write memories and takes one beat at a
// time. A degenerate or bad-index beat goes straight from the check to its result. An add
// scans the vertex store, reading and then comparing each stored vertex, and is rejected
// when a store would overflow; otherwise it writes the missing endpoints and the line. A
// delete shifts the line store down over the index, scans the remaining lines for
// references to its endpoints, and for each dropped vertex shifts the vertex store and
// renumbers every line. Each memory element is read into a register before it is compared
// or written back. A finished result waits in an output register while the next beat is
// accepted.

module indexed_line_mesh_table_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  idxlm_pkg::req_beat_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output idxlm_pkg::rsp_beat_type rsp_data
);

   idxlm_pkg::cmd_type cmd;
   idxlm_pkg::dp_status_type stat;

   idxlm_controller u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .stat(stat),
      .cmd(cmd)
   );

   idxlm_datapath u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .stat(stat),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the indexed line mesh table: directed table, then random beats.
`timescale 1ns / 1ps

module tb;

   localparam int LIMIT_CYCLES = 20000000;

   typedef struct {
      idxlm_pkg::req_beat_type req;
      bit                      typed;
      idxlm_pkg::rsp_beat_type rsp;
   } table_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   idxlm_pkg::req_beat_type req_data = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   idxlm_pkg::rsp_beat_type rsp_data;

   logic [idxlm_pkg::COORD_BITS-1:0] mesh_vx [idxlm_pkg::MAX_VERTICES];
   logic [idxlm_pkg::COORD_BITS-1:0] mesh_vy [idxlm_pkg::MAX_VERTICES];
   int                               mesh_ls [idxlm_pkg::MAX_LINES];
   int                               mesh_le [idxlm_pkg::MAX_LINES];
   int                               mesh_vc = 0;
   int                               mesh_lc = 0;

   idxlm_pkg::rsp_beat_type pending_rsp [$];
   table_row_type           dir_rows [$];
   int                      error_count = 0;
   int                      cycle_count = 0;
   int                      hold_cycles = 0;
   bit                      no_idle = 0;

   indexed_line_mesh_table_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   function automatic int find_vertex(logic [idxlm_pkg::COORD_BITS-1:0] x,
                                      logic [idxlm_pkg::COORD_BITS-1:0] y);
      for (int i = 0; i < mesh_vc; i++) begin
         if (mesh_vx[i] == x && mesh_vy[i] == y) return i;
      end
      return mesh_vc;
   endfunction

   function automatic void drop_vertex(int v);
      for (int i = v; i + 1 < mesh_vc; i++) begin
         mesh_vx[i] = mesh_vx[i+1];
         mesh_vy[i] = mesh_vy[i+1];
      end
      mesh_vc--;
      for (int i = 0; i < mesh_lc; i++) begin
         if (mesh_ls[i] > v) mesh_ls[i]--;
         if (mesh_le[i] > v) mesh_le[i]--;
      end
   endfunction

   function automatic idxlm_pkg::rsp_beat_type mesh_apply(idxlm_pkg::req_beat_type r);
      idxlm_pkg::rsp_beat_type    o;
      idxlm_pkg::status_code_type st;
      int a, b, need, fv, sv, idx, s0, e0;
      bit keep_s, keep_e;
      st = idxlm_pkg::ST_DONE;
      fv = 0;
      sv = 0;
      if (r.func == idxlm_pkg::FUNC_ADD) begin
         if (r.start_x == r.end_x && r.start_y == r.end_y) begin
            st = idxlm_pkg::ST_DEGEN;
         end else begin
            a = find_vertex(r.start_x, r.start_y);
            b = find_vertex(r.end_x, r.end_y);
            need = 0;
            if (a == mesh_vc) need++;
            if (b == mesh_vc) need++;
            if (mesh_lc >= idxlm_pkg::MAX_LINES || mesh_vc + need > idxlm_pkg::MAX_VERTICES)
            begin
               st = idxlm_pkg::ST_FULL;
            end else begin
               if (a == mesh_vc) begin
                  mesh_vx[mesh_vc] = r.start_x;
                  mesh_vy[mesh_vc] = r.start_y;
                  mesh_vc++;
               end
               b = find_vertex(r.end_x, r.end_y);
               if (b == mesh_vc) begin
                  mesh_vx[mesh_vc] = r.end_x;
                  mesh_vy[mesh_vc] = r.end_y;
                  mesh_vc++;
               end
               mesh_ls[mesh_lc] = a;
               mesh_le[mesh_lc] = b;
               mesh_lc++;
               fv = a;
               sv = b;
            end
         end
      end else begin
         idx = r.line_index;
         if (idx >= mesh_lc) begin
            st = idxlm_pkg::ST_BADIDX;
         end else begin
            s0 = mesh_ls[idx];
            e0 = mesh_le[idx];
            keep_s = 0;
            keep_e = 0;
            for (int i = idx; i + 1 < mesh_lc; i++) begin
               mesh_ls[i] = mesh_ls[i+1];
               mesh_le[i] = mesh_le[i+1];
            end
            mesh_lc--;
            for (int i = 0; i < mesh_lc; i++) begin
               if (mesh_ls[i] == s0 || mesh_le[i] == s0) keep_s = 1;
               if (mesh_ls[i] == e0 || mesh_le[i] == e0) keep_e = 1;
            end
            if (s0 == e0) keep_e = 1;
            if (!keep_s && s0 < mesh_vc) begin
               drop_vertex(s0);
               if (e0 > s0) e0--;
            end
            if (!keep_e && e0 < mesh_vc) drop_vertex(e0);
         end
      end
      o.status = st;
      o.first_vertex = fv[idxlm_pkg::VIDX_BITS-1:0];
      o.second_vertex = sv[idxlm_pkg::VIDX_BITS-1:0];
      o.lines_held = mesh_lc[idxlm_pkg::LCNT_BITS-1:0];
      o.vertices_held = mesh_vc[idxlm_pkg::VCNT_BITS-1:0];
      return o;
   endfunction

   function automatic idxlm_pkg::req_beat_type make_req(idxlm_pkg::func_type f, int sx,
                                                        int sy, int ex, int ey, int idx);
      idxlm_pkg::req_beat_type r;
      r.func = f;
      r.start_x = sx[15:0];
      r.start_y = sy[15:0];
      r.end_x = ex[15:0];
      r.end_y = ey[15:0];
      r.line_index = idx[7:0];
      return r;
   endfunction

   function automatic idxlm_pkg::rsp_beat_type make_rsp(idxlm_pkg::status_code_type st,
                                                        int fv, int sv, int lc, int vc);
      idxlm_pkg::rsp_beat_type o;
      o.status = st;
      o.first_vertex = fv[7:0];
      o.second_vertex = sv[7:0];
      o.lines_held = lc[8:0];
      o.vertices_held = vc[8:0];
      return o;
   endfunction

   function automatic int idle_gap();
      int p;
      if (no_idle) return 0;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic add_row(idxlm_pkg::req_beat_type r, bit typed, idxlm_pkg::rsp_beat_type o);
      table_row_type row;
      row.req = r;
      row.typed = typed;
      row.rsp = o;
      dir_rows.push_back(row);
   endtask

   task automatic send_beat(idxlm_pkg::req_beat_type r, bit typed,
                            idxlm_pkg::rsp_beat_type typed_rsp);
      idxlm_pkg::rsp_beat_type predicted;
      int n;
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      predicted = mesh_apply(r);
      pending_rsp.push_back(typed ? typed_rsp : predicted);
      @(negedge clock);
      n = idle_gap();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   task automatic send_pred(idxlm_pkg::req_beat_type r);
      send_beat(r, 1'b0, '0);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   function automatic int pool_coord();
      int pool [6] = '{-32768, 32767, 0, -1, 1, 100};
      return pool[$urandom_range(0, 5)];
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("** indexed_line_mesh_table_core: FAILED **");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else if (no_idle) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) < 70) ? 1'b1 : ($urandom_range(0, 9) == 0);
      end
   end

   always @(posedge clock) begin
      idxlm_pkg::rsp_beat_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("result beat with no expectation waiting");
            error_count++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_data.status != e.status) begin
               $error("status expected %0d got %0d", e.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.first_vertex != e.first_vertex) begin
               $error("first_vertex expected %0d got %0d", e.first_vertex,
                      rsp_data.first_vertex);
               error_count++;
            end
            if (rsp_data.second_vertex != e.second_vertex) begin
               $error("second_vertex expected %0d got %0d", e.second_vertex,
                      rsp_data.second_vertex);
               error_count++;
            end
            if (rsp_data.lines_held != e.lines_held) begin
               $error("lines_held expected %0d got %0d", e.lines_held, rsp_data.lines_held);
               error_count++;
            end
            if (rsp_data.vertices_held != e.vertices_held) begin
               $error("vertices_held expected %0d got %0d", e.vertices_held,
                      rsp_data.vertices_held);
               error_count++;
            end
         end
      end
   end

   initial begin
      int bx, by, idx, span;
      idxlm_pkg::req_beat_type r;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      add_row(make_req(idxlm_pkg::FUNC_DELETE, 0, 0, 0, 0, 0), 1,
              make_rsp(idxlm_pkg::ST_BADIDX, 0, 0, 0, 0));
      add_row(make_req(idxlm_pkg::FUNC_ADD, -32768, -32768, -32768, -32768, 255), 1,
              make_rsp(idxlm_pkg::ST_DEGEN, 0, 0, 0, 0));
      add_row(make_req(idxlm_pkg::FUNC_ADD, 32767, 32767, 32767, 32767, 0), 1,
              make_rsp(idxlm_pkg::ST_DEGEN, 0, 0, 0, 0));
      add_row(make_req(idxlm_pkg::FUNC_ADD, -32768, -32768, 32767, 32767, 0), 1,
              make_rsp(idxlm_pkg::ST_DONE, 0, 1, 1, 2));
      add_row(make_req(idxlm_pkg::FUNC_ADD, 32767, 32767, -32768, -32768, 0), 1,
              make_rsp(idxlm_pkg::ST_DONE, 1, 0, 2, 2));
      add_row(make_req(idxlm_pkg::FUNC_ADD, 32767, -32768, -32768, 32767, 0), 1,
              make_rsp(idxlm_pkg::ST_DONE, 2, 3, 3, 4));
      add_row(make_req(idxlm_pkg::FUNC_ADD, 0, 0, 32767, 32767, 0), 0, '0);
      add_row(make_req(idxlm_pkg::FUNC_DELETE, 0, 0, 0, 0, 255), 1,
              make_rsp(idxlm_pkg::ST_BADIDX, 0, 0, 4, 5));
      add_row(make_req(idxlm_pkg::FUNC_DELETE, -1, -1, -1, -1, 4), 1,
              make_rsp(idxlm_pkg::ST_BADIDX, 0, 0, 4, 5));
      add_row(make_req(idxlm_pkg::FUNC_DELETE, 0, 0, 0, 0, 0), 0, '0);
      add_row(make_req(idxlm_pkg::FUNC_DELETE, 0, 0, 0, 0, 1), 0, '0);
      add_row(make_req(idxlm_pkg::FUNC_ADD, -1, -1, 1, 1, 0), 0, '0);
      add_row(make_req(idxlm_pkg::FUNC_ADD, 0, 0, -1, -1, 0), 0, '0);
      add_row(make_req(idxlm_pkg::FUNC_DELETE, 0, 0, 0, 0, 0), 0, '0);
      add_row(make_req(idxlm_pkg::FUNC_DELETE, 0, 0, 0, 0, 2), 0, '0);
      add_row(make_req(idxlm_pkg::FUNC_DELETE, 0, 0, 0, 0, 0), 0, '0);
      add_row(make_req(idxlm_pkg::FUNC_DELETE, 0, 0, 0, 0, 0), 0, '0);
      add_row(make_req(idxlm_pkg::FUNC_DELETE, 0, 0, 0, 0, 0), 0, '0);
      foreach (dir_rows[i]) send_beat(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
      wait_drained();

      // Chain of lines until the vertex store and then the line store are full.
      bx = $urandom_range(0, 65535);
      by = $urandom_range(0, 65535);
      no_idle = 1;
      for (int i = 0; i < 256; i++) begin
         send_pred(make_req(idxlm_pkg::FUNC_ADD, bx + i, by, bx + i + 1, by, 0));
      end
      no_idle = 0;
      send_pred(make_req(idxlm_pkg::FUNC_ADD, bx, by, bx + 2, by, 0));
      send_pred(make_req(idxlm_pkg::FUNC_ADD, bx + 3, by, bx + 5, by, 0));
      send_pred(make_req(idxlm_pkg::FUNC_ADD, bx + 1, by, bx + 7, by, 0));

      while (mesh_lc > 128) begin
         if ($urandom_range(0, 9) == 0) begin
            r = make_req(idxlm_pkg::FUNC_DELETE, $urandom, $urandom, $urandom, $urandom,
                         $urandom);
         end else if ($urandom_range(0, 19) == 0) begin
            r = make_req(idxlm_pkg::FUNC_ADD, bx + $urandom_range(0, 300), by,
                         bx + $urandom_range(0, 300), by, $urandom);
         end else begin
            span = (mesh_lc > 4) ? 3 : mesh_lc - 1;
            idx = mesh_lc - 1 - $urandom_range(0, span);
            r = make_req(idxlm_pkg::FUNC_DELETE, $urandom, $urandom, $urandom, $urandom, idx);
         end
         send_pred(r);
      end
      wait_drained();

      // Receiver holds off while quick beats pile up behind the output register.
      @(negedge clock);
      hold_cycles = 400;
      for (int i = 0; i < 20; i++) begin
         send_pred(make_req(idxlm_pkg::FUNC_DELETE, 0, 0, 0, 0, 200 + i));
      end
      wait_drained();

      for (int i = 0; i < 160; i++) begin
         if ($urandom_range(0, 9) < 2) begin
            r = make_req(idxlm_pkg::func_type'($urandom_range(0, 1)), $urandom, $urandom,
                         $urandom, $urandom, $urandom);
         end else if ($urandom_range(0, 9) < 6) begin
            r = make_req(idxlm_pkg::FUNC_ADD, pool_coord(), pool_coord(), pool_coord(),
                         pool_coord(), $urandom);
         end else begin
            r = make_req(idxlm_pkg::FUNC_DELETE, $urandom, $urandom, $urandom, $urandom,
                         $urandom_range(0, mesh_lc));
         end
         if (i == 80) no_idle = 1;
         if (i == 110) no_idle = 0;
         send_pred(r);
      end
      wait_drained();
      repeat (200) @(posedge clock);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("** indexed_line_mesh_table_core: PASSED **");
      end else begin
         $display("** indexed_line_mesh_table_core: FAILED **");
      end
      $finish;
   end
endmodule
